@@ src/dapid_pkg.sv @@
// Package for the two-axis PID position controller.
// Widths, register codes, reset values and the per-axis PID arithmetic.
// No dependencies.
package dapid_pkg;

    // Field widths
    localparam int SUM_WIDTH      = 16;
    localparam int COORD_WIDTH    = 8;
    localparam int GAIN_WIDTH     = 12;
    localparam int DB_WIDTH       = 8;
    localparam int DRIVE_WIDTH    = 32;
    localparam int ERR_WIDTH      = COORD_WIDTH + 1;
    localparam int DE_WIDTH       = COORD_WIDTH + 2;
    localparam int ACC_WIDTH      = SUM_WIDTH + ERR_WIDTH;
    localparam int PID_WIDTH      = GAIN_WIDTH + 1 + SUM_WIDTH + DE_WIDTH;
    localparam int SAT_WIDTH      = PID_WIDTH + DRIVE_WIDTH;
    localparam int CMP_WIDTH      = ERR_WIDTH + DB_WIDTH;
    localparam int CFG_DATA_WIDTH = (GAIN_WIDTH > COORD_WIDTH) ? GAIN_WIDTH : COORD_WIDTH;
    localparam int CFG_IDX_WIDTH  = 3;

    typedef logic        [COORD_WIDTH-1:0] coord_t;
    typedef logic        [GAIN_WIDTH-1:0]  gain_t;
    typedef logic        [DB_WIDTH-1:0]    db_t;
    typedef logic signed [ERR_WIDTH-1:0]   err_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;
    typedef logic signed [PID_WIDTH-1:0]   pid_t;
    typedef logic signed [DRIVE_WIDTH-1:0] drive_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_TARGET_X    = 3'd3,
        REG_TARGET_Y    = 3'd4,
        REG_DEADBAND    = 3'd5,
        REG_HOLD_ENABLE = 3'd6
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam gain_t  GAIN_P_RESET   = GAIN_WIDTH'(57);
    localparam gain_t  GAIN_I_RESET   = GAIN_WIDTH'(5);
    localparam gain_t  GAIN_D_RESET   = GAIN_WIDTH'(1120);
    localparam coord_t TARGET_X_RESET = COORD_WIDTH'(104);
    localparam coord_t TARGET_Y_RESET = COORD_WIDTH'(94);
    localparam db_t    DEADBAND_RESET = DB_WIDTH'(5);

    // Saturation limits
    localparam sum_t   SUM_MAX   = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam sum_t   SUM_MIN   = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam drive_t DRIVE_MAX = {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
    localparam drive_t DRIVE_MIN = {1'b1, {(DRIVE_WIDTH-1){1'b0}}};

    // Result of one axis step
    typedef struct packed {
        err_t err;
        sum_t sum;
        pid_t pid;
    } axis_t;

    // Error, saturating integral, derivative and PID sum for one axis
    function automatic axis_t axis_step(
        input coord_t target,
        input coord_t meas,
        input sum_t   sum,
        input err_t   last,
        input gain_t  kp,
        input gain_t  ki,
        input gain_t  kd
    );
        logic signed [ERR_WIDTH-1:0]             err;
        logic signed [DE_WIDTH-1:0]              de;
        logic signed [ACC_WIDTH-1:0]             acc;
        logic signed [SUM_WIDTH-1:0]             sum_new;
        logic signed [GAIN_WIDTH+ERR_WIDTH:0]    p_term;
        logic signed [GAIN_WIDTH+SUM_WIDTH:0]    i_term;
        logic signed [GAIN_WIDTH+DE_WIDTH:0]     d_term;
        axis_t                                   r;
        err = $signed({1'b0, target}) - $signed({1'b0, meas});
        de  = DE_WIDTH'(err) - DE_WIDTH'(last);
        acc = ACC_WIDTH'(sum) + ACC_WIDTH'(err);
        if (acc > ACC_WIDTH'(SUM_MAX))
            sum_new = SUM_MAX;
        else if (acc < ACC_WIDTH'(SUM_MIN))
            sum_new = SUM_MIN;
        else
            sum_new = acc[SUM_WIDTH-1:0];
        p_term = $signed({1'b0, kp}) * err;
        i_term = $signed({1'b0, ki}) * sum_new;
        d_term = $signed({1'b0, kd}) * de;
        r.err = err;
        r.sum = sum_new;
        r.pid = PID_WIDTH'(p_term) + PID_WIDTH'(i_term) + PID_WIDTH'(d_term);
        return r;
    endfunction

    // Clamp a PID value to the signed drive range
    function automatic drive_t sat_drive(input pid_t v);
        drive_t r;
        if (SAT_WIDTH'(v) > SAT_WIDTH'(DRIVE_MAX))
            r = DRIVE_MAX;
        else if (SAT_WIDTH'(v) < SAT_WIDTH'(DRIVE_MIN))
            r = DRIVE_MIN;
        else
            r = DRIVE_WIDTH'(v);
        return r;
    endfunction

    // Magnitude of an error, unsigned, widened for the deadband compare
    function automatic logic [CMP_WIDTH-1:0] err_mag(input err_t e);
        logic [ERR_WIDTH-1:0] m;
        m = e[ERR_WIDTH-1] ? ERR_WIDTH'(-e) : ERR_WIDTH'(e);
        return CMP_WIDTH'(m);
    endfunction

endpackage

@@ src/dual_axis_pid_position_top.sv @@
// Top level of the two-axis PID position controller.
// Depends on dapid_pkg for widths, register codes and the axis arithmetic.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one measured_x/measured_y sample
//   per transfer. Output channel (out_valid/out_ready) carries drive_x, drive_y
//   and settled, one result per sample, in order.
//   A sample passes through the input register and then the result register.
//   Throughput: one sample per cycle while the output is not stalled; the
//   input register and the result register each hold one item, so a stalled
//   output still lets one more sample enter before in_ready drops.
//   The PID pass is three multiplies per axis between the input register and
//   the result register; integral, previous error and held drives update at
//   the same edge that loads the result, so the next sample sees them at once.
//   Configuration: cfg_write/cfg_index/cfg_data write one register per cycle,
//   unknown indexes are ignored; write only while no sample is in flight.
//   Reset: gains, targets, deadband and hold take their defaults, integrals,
//   previous errors and held drives clear, both channels empty.
//   A stalled receiver holds the result register and, once the input
//   register is also full, deasserts in_ready.
module dual_axis_pid_position_top
    import dapid_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [COORD_WIDTH-1:0]      measured_x,
    input  logic [COORD_WIDTH-1:0]      measured_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [DRIVE_WIDTH-1:0] drive_x,
    output logic signed [DRIVE_WIDTH-1:0] drive_y,
    output logic                        settled
);

    // Configuration registers
    gain_t  gain_p_reg, gain_i_reg, gain_d_reg;
    coord_t target_x_reg, target_y_reg;
    db_t    deadband_reg;
    logic   hold_enable_reg;

    // Pipeline control and payload
    logic   in_valid_reg, in_valid_next;
    logic   out_valid_reg, out_valid_next;
    coord_t meas_x_reg, meas_y_reg;
    drive_t drive_x_reg, drive_x_next;
    drive_t drive_y_reg, drive_y_next;
    logic   settled_reg;

    // Controller state
    sum_t   sum_x_reg, sum_y_reg;
    err_t   last_err_x_reg, last_err_y_reg;
    drive_t held_x_reg, held_y_reg;

    // Combinational PID pass
    axis_t  axis_x, axis_y;
    logic   advance;
    logic   in_take;
    logic   settled_now;
    logic   hold_now;
    drive_t new_x, new_y;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg      <= GAIN_P_RESET;
            gain_i_reg      <= GAIN_I_RESET;
            gain_d_reg      <= GAIN_D_RESET;
            target_x_reg    <= TARGET_X_RESET;
            target_y_reg    <= TARGET_Y_RESET;
            deadband_reg    <= DEADBAND_RESET;
            hold_enable_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_GAIN_P:      gain_p_reg      <= cfg_data[GAIN_WIDTH-1:0];
                REG_GAIN_I:      gain_i_reg      <= cfg_data[GAIN_WIDTH-1:0];
                REG_GAIN_D:      gain_d_reg      <= cfg_data[GAIN_WIDTH-1:0];
                REG_TARGET_X:    target_x_reg    <= cfg_data[COORD_WIDTH-1:0];
                REG_TARGET_Y:    target_y_reg    <= cfg_data[COORD_WIDTH-1:0];
                REG_DEADBAND:    deadband_reg    <= cfg_data[DB_WIDTH-1:0];
                REG_HOLD_ENABLE: hold_enable_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Handshake: advance when the input register is full and the result slot frees
    assign advance       = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready      = !in_valid_reg || advance;
    assign in_take       = in_valid && in_ready;
    assign in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // PID pass for both axes
    always_comb
    begin
        axis_x = axis_step(target_x_reg, meas_x_reg, sum_x_reg, last_err_x_reg,
                           gain_p_reg, gain_i_reg, gain_d_reg);
        axis_y = axis_step(target_y_reg, meas_y_reg, sum_y_reg, last_err_y_reg,
                           gain_p_reg, gain_i_reg, gain_d_reg);
        new_x  = sat_drive(-axis_x.pid);
        new_y  = sat_drive(axis_y.pid);
        settled_now = (err_mag(axis_x.err) <= CMP_WIDTH'(deadband_reg)) &&
                      (err_mag(axis_y.err) <= CMP_WIDTH'(deadband_reg));
        hold_now     = settled_now && hold_enable_reg;
        drive_x_next = hold_now ? held_x_reg : new_x;
        drive_y_next = hold_now ? held_y_reg : new_y;
    end

    // Hold control flags and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            last_err_x_reg <= '0;
            last_err_y_reg <= '0;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                sum_x_reg      <= axis_x.sum;
                sum_y_reg      <= axis_y.sum;
                last_err_x_reg <= axis_x.err;
                last_err_y_reg <= axis_y.err;
                held_x_reg     <= drive_x_next;
                held_y_reg     <= drive_y_next;
            end
        end
    end

    // Capture sample and result payloads
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            meas_x_reg <= measured_x;
            meas_y_reg <= measured_y;
        end
        if (advance)
        begin
            drive_x_reg <= drive_x_next;
            drive_y_reg <= drive_y_next;
            settled_reg <= settled_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive_x   = drive_x_reg;
    assign drive_y   = drive_y_reg;
    assign settled   = settled_reg;

    // A held step repeats the previously held drives
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && hold_now |=> drive_x_reg == $past(held_x_reg) &&
                                drive_y_reg == $past(held_y_reg))
        else $error("held drive not repeated");

    // Each result leaves the held drives equal to what was output
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && held_x_reg == drive_x_reg &&
                    held_y_reg == drive_y_reg)
        else $error("held drives diverge from output");

    // Integral and previous error move only with a result
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(sum_x_reg) && $stable(sum_y_reg) &&
                     $stable(last_err_x_reg) && $stable(last_err_y_reg))
        else $error("state changed without a result");

    // An empty input register is always ready for a sample
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input stalled while empty");

endmodule
